FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies; expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TKE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TKE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/tke_pkg.sv
// Shared types, constants and helpers of the tilt estimator.
// No dependencies; imported by every module of the block.
package tke_pkg;

    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 29;
    localparam int DIV_W           = 64;
    localparam int Q28_SHIFT       = 28;
    localparam int RATE_SHIFT      = 15;
    localparam int TIME_RECIP_SHIFT = 53;

    localparam logic signed [8:0]  RATE_GAIN    = 9'sd250;
    localparam logic signed [24:0] RATE_ROUND   = 25'sd32767;
    localparam logic signed [10:0] TILT_ZERO    = 11'sd256;
    localparam logic [43:0]        TIME_RECIP   = 44'h83126E978D5;
    localparam logic signed [63:0] Q28_ROUND    = 64'sd268435455;
    localparam logic signed [26:0] EST_MAX      = 27'sd67108863;
    localparam logic signed [26:0] EST_MIN      = -27'sd67108864;

    localparam logic [28:0]        ANGLE_NOISE_RST   = 29'd268435;
    localparam logic [28:0]        BIAS_NOISE_RST    = 29'd805306;
    localparam logic [28:0]        MEASURE_NOISE_RST = 29'd8053063;
    localparam logic signed [10:0] TILT_OFFSET_RST   = 11'sd36;
    localparam logic [9:0]         TILT_LIMIT_RST    = 10'd150;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_OFFSET   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT_LIMIT    = 3'd4;

    typedef struct packed {
        logic [28:0]        angle_noise;
        logic [28:0]        bias_noise;
        logic [28:0]        measure_noise;
        logic signed [10:0] tilt_offset;
        logic [9:0]         tilt_limit;
    } tke_cfg_t;

    typedef struct packed {
        logic [24:0]       num;
        logic [16:0]       den;
        logic              neg;
        logic              zero;
        logic signed [8:0] rate;
        logic [9:0]        ms;
    } tke_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL0,
        ST_MUL1,
        ST_DIV,
        ST_DIVW,
        ST_RECIP,
        ST_WB,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        STEP_TILT,
        STEP_ANG_T,
        STEP_CAA_T,
        STEP_CBB_T,
        STEP_BN_T,
        STEP_K0,
        STEP_K1,
        STEP_ANG_C,
        STEP_BIAS_C,
        STEP_CAA_C,
        STEP_CAB_C,
        STEP_CBA_C,
        STEP_CBB_C
    } step_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [63:0] shr28(input logic signed [63:0] p);
        logic signed [63:0] r;
        r = (p + (p < 0 ? Q28_ROUND : 64'sd0)) >>> Q28_SHIFT;
        return r;
    endfunction

endpackage

FILE: hw/rtl/tke_front.sv
// Front end: takes input words, forms rate and arctan2 operands, pushes to queue.
// Depends on tke_pkg.
module tke_front (
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    input  logic [9:0]         interval_ms,
    input  logic               queue_full,
    output logic               push,
    output tke_pkg::tke_item_t push_item
);
    import tke_pkg::*;

    logic signed [16:0] ty;
    logic signed [16:0] tx;
    logic [16:0]        mag_y;
    logic [16:0]        mag_x;
    logic signed [24:0] gp;
    logic signed [24:0] gq;

    always_comb
    begin
        ty    = 17'sd0 - 17'(accel_z);
        tx    = 17'sd0 - 17'(accel_y);
        mag_y = ty[16] ? 17'(17'sd0 - ty) : 17'(ty);
        mag_x = tx[16] ? 17'(17'sd0 - tx) : 17'(tx);
        gp    = 25'(gyro_x) * 25'(RATE_GAIN);
        gq    = (gp + (gp < 0 ? RATE_ROUND : 25'sd0)) >>> RATE_SHIFT;

        push_item.num  = {mag_y, 8'd0} + (tx[16] ? {mag_x[15:0], 9'd0} : 25'd0);
        push_item.den  = mag_x + mag_y;
        push_item.neg  = ty[16];
        push_item.zero = (mag_x == 17'd0) && (mag_y == 17'd0);
        push_item.rate = gq[8:0];
        push_item.ms   = interval_ms;

        in_ready = !queue_full;
        push     = in_valid && !queue_full;
    end

endmodule

FILE: hw/rtl/tke_queue.sv
// Small word queue between front end and filter sequencer.
// Depends on tke_pkg.
module tke_queue #(
    parameter int DEPTH = tke_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tke_pkg::tke_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output tke_pkg::tke_item_t pop_item
);
    import tke_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tke_item_t        mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    always_comb
    begin
        full     = (count_reg == CNT_W'(DEPTH));
        valid    = (count_reg != '0);
        pop_item = mem[rd_ptr_reg];
        do_push  = push && !full;
        do_pop   = pop && valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hw/rtl/tke_div.sv
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on tke_pkg.
module tke_div #(
    parameter int W = tke_pkg::DIV_W
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [W-1:0] dividend,
    input  logic signed [W-1:0] divisor,
    output logic                done,
    output logic signed [W-1:0] quotient
);
    import tke_pkg::*;

    localparam int CNT_W = $clog2(W + 1);

    logic [W:0]       rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic [W:0]       shifted;
    logic             ge;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[W-1:0], quo_reg[W-1]};
        ge        = (shifted >= {1'b0, dvs_reg});

        if (start)
        begin
            rem_next = '0;
            quo_next = dividend[W-1] ? W'(-dividend) : W'(dividend);
            dvs_next = divisor[W-1] ? W'(-divisor) : W'(divisor);
            neg_next = dividend[W-1] ^ divisor[W-1];
            cnt_next = CNT_W'(W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = ge ? (shifted - {1'b0, dvs_reg}) : shifted;
            quo_next  = {quo_reg[W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end

        done     = done_reg;
        quotient = neg_reg ? W'(-$signed(quo_reg)) : $signed(quo_reg);
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

endmodule

FILE: hw/rtl/tke_back.sv
// Filter sequencer: arctan2, prediction and correction over a shared
// multiplier and divider, plus the output register. Depends on tke_pkg, tke_div.
module tke_back (
    input  logic               clk,
    input  logic               rst_n,
    input  tke_pkg::tke_cfg_t  cfg,
    input  logic               q_valid,
    input  tke_pkg::tke_item_t q_item,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [26:0] angle_estimate,
    output logic signed [11:0] raw_tilt,
    output logic               too_far
);
    import tke_pkg::*;

    state_t             state_reg, state_next;
    step_t              step_reg, step_next;
    tke_item_t          item_reg, item_next;
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic signed [31:0] caa_reg, caa_next;
    logic signed [31:0] cab_reg, cab_next;
    logic signed [31:0] cba_reg, cba_next;
    logic signed [31:0] cbb_reg, cbb_next;
    logic signed [31:0] k0_reg, k0_next;
    logic signed [31:0] k1_reg, k1_next;
    logic signed [11:0] raw_reg, raw_next;
    logic signed [33:0] y_reg, y_next;
    logic signed [51:0] lo_reg, lo_next;
    logic signed [63:0] pp_reg, pp_next;
    logic signed [63:0] q_reg, q_next;
    logic               ov_reg, ov_next;
    logic signed [26:0] est_reg, est_next;
    logic signed [11:0] rout_reg, rout_next;
    logic               far_reg, far_next;
    logic [86:0]        rc_acc_reg, rc_acc_next;
    logic [2:0]         rc_cnt_reg, rc_cnt_next;

    logic signed [33:0] ma, mb, s_w;
    logic signed [17:0] b_lo;
    logic signed [16:0] b_hi;
    logic signed [50:0] hi_w;
    logic signed [67:0] prod;
    logic signed [63:0] dvd, dvs, quo;
    logic               div_start, div_done;
    logic signed [10:0] ang;
    logic signed [12:0] rawx, limx;
    step_t              step_inc;
    logic [42:0]        rc_mag;
    logic [10:0]        rc_digit;
    logic [53:0]        rc_prod;
    logic [63:0]        rc_quo;

    tke_div #(.W(DIV_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dvd),
        .divisor  (dvs),
        .done     (div_done),
        .quotient (quo)
    );

    always_comb
    begin
        s_w = 34'(caa_reg) + $signed({5'd0, cfg.measure_noise});

        case (step_reg)
            STEP_ANG_T:  ma = 34'($signed({item_reg.rate, 16'd0})) - 34'(bias_reg);
            STEP_CAA_T:  ma = $signed({5'd0, cfg.angle_noise}) - 34'(cba_reg) - 34'(cab_reg);
            STEP_CBB_T:  ma = 34'(cbb_reg);
            STEP_BN_T:   ma = $signed({5'd0, cfg.bias_noise});
            STEP_ANG_C, STEP_CAA_C, STEP_CAB_C: ma = 34'(k0_reg);
            default:     ma = 34'(k1_reg);
        endcase
        case (step_reg)
            STEP_ANG_C, STEP_BIAS_C: mb = y_reg;
            STEP_CAA_C, STEP_CBA_C:  mb = 34'(caa_reg);
            STEP_CAB_C, STEP_CBB_C:  mb = 34'(cab_reg);
            default:                 mb = $signed({24'd0, item_reg.ms});
        endcase
        b_lo = $signed({1'b0, mb[16:0]});
        b_hi = mb[33:17];
        hi_w = 51'(ma) * 51'(b_hi);
        prod = (68'(hi_w) <<< 17) + 68'(lo_reg);

        case (step_reg)
            STEP_TILT:
            begin
                dvd = $signed({39'd0, item_reg.num});
                dvs = $signed({47'd0, item_reg.den});
            end
            STEP_K1:
            begin
                dvd = 64'(cba_reg) <<< Q28_SHIFT;
                dvs = 64'(s_w);
            end
            default:
            begin
                dvd = 64'(caa_reg) <<< Q28_SHIFT;
                dvs = 64'(s_w);
            end
        endcase

        rc_mag = pp_reg[63] ? 43'(64'sd0 - pp_reg) : pp_reg[42:0];
        case (rc_cnt_reg)
            3'd0:    rc_digit = TIME_RECIP[43:33];
            3'd1:    rc_digit = TIME_RECIP[32:22];
            3'd2:    rc_digit = TIME_RECIP[21:11];
            default: rc_digit = TIME_RECIP[10:0];
        endcase
        rc_prod = 54'(rc_mag) * 54'(rc_digit);
        rc_quo  = {30'd0, rc_acc_reg[86:TIME_RECIP_SHIFT]};

        ang = item_reg.zero ? TILT_ZERO : $signed({1'b0, q_reg[9:0]});
        if (item_reg.neg)
            ang = 11'sd0 - ang;

        step_inc = step_t'(step_reg + 4'd1);

        state_next  = state_reg;
        step_next   = step_reg;
        item_next   = item_reg;
        angle_next  = angle_reg;
        bias_next   = bias_reg;
        caa_next    = caa_reg;
        cab_next    = cab_reg;
        cba_next    = cba_reg;
        cbb_next    = cbb_reg;
        k0_next     = k0_reg;
        k1_next     = k1_reg;
        raw_next    = raw_reg;
        y_next      = y_reg;
        lo_next     = lo_reg;
        pp_next     = pp_reg;
        q_next      = q_reg;
        ov_next     = ov_reg && !out_ready;
        est_next    = est_reg;
        rout_next   = rout_reg;
        far_next    = far_reg;
        rc_acc_next = rc_acc_reg;
        rc_cnt_next = rc_cnt_reg;
        q_pop       = 1'b0;
        div_start   = 1'b0;
        rawx        = 13'(raw_reg);
        limx        = $signed({3'd0, cfg.tilt_limit});

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    step_next  = STEP_TILT;
                    state_next = q_item.zero ? ST_WB : ST_DIV;
                end
            end
            ST_MUL0:
            begin
                lo_next    = 52'(ma) * 52'(b_lo);
                state_next = ST_MUL1;
            end
            ST_MUL1:
            begin
                pp_next     = prod[63:0];
                rc_acc_next = '0;
                rc_cnt_next = '0;
                state_next  = (step_reg inside {STEP_ANG_T, STEP_CAA_T, STEP_CBB_T, STEP_BN_T})
                              ? ST_RECIP : ST_WB;
            end
            ST_RECIP:
            begin
                if (rc_cnt_reg == 3'd4)
                begin
                    q_next     = pp_reg[63] ? $signed(64'd0 - rc_quo) : $signed(rc_quo);
                    state_next = ST_WB;
                end
                else
                begin
                    rc_acc_next = {rc_acc_reg[75:0], 11'd0} + 87'(rc_prod);
                    rc_cnt_next = rc_cnt_reg + 3'd1;
                end
            end
            ST_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    q_next     = quo;
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                case (step_reg)
                    STEP_TILT:   raw_next = 12'(ang) - 12'(cfg.tilt_offset);
                    STEP_ANG_T:  angle_next = sat32(64'(angle_reg) + q_reg);
                    STEP_CAA_T:  caa_next = sat32(64'(caa_reg) + q_reg);
                    STEP_CBB_T:
                    begin
                        cab_next = sat32(64'(cab_reg) - q_reg);
                        cba_next = sat32(64'(cba_reg) - q_reg);
                    end
                    STEP_BN_T:
                    begin
                        cbb_next = sat32(64'(cbb_reg) + q_reg);
                        y_next   = $signed({raw_reg, 16'd0}) - 34'(angle_reg);
                    end
                    STEP_K0:     k0_next = (s_w == 34'sd0) ? 32'sd0 : sat32(q_reg);
                    STEP_K1:     k1_next = (s_w == 34'sd0) ? 32'sd0 : sat32(q_reg);
                    STEP_ANG_C:  angle_next = sat32(64'(angle_reg) + shr28(pp_reg));
                    STEP_BIAS_C: bias_next = sat32(64'(bias_reg) + shr28(pp_reg));
                    STEP_CAA_C:  caa_next = sat32(64'(caa_reg) - shr28(pp_reg));
                    STEP_CAB_C:  cab_next = sat32(64'(cab_reg) - shr28(pp_reg));
                    STEP_CBA_C:  cba_next = sat32(64'(cba_reg) - shr28(pp_reg));
                    default:     cbb_next = sat32(64'(cbb_reg) - shr28(pp_reg));
                endcase

                if (step_reg == STEP_CBB_C)
                    state_next = ST_OUT;
                else
                begin
                    step_next = step_inc;
                    if (step_inc inside {STEP_K0, STEP_K1})
                        state_next = (s_w == 34'sd0) ? ST_WB : ST_DIV;
                    else
                        state_next = ST_MUL0;
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    rout_next  = raw_reg;
                    far_next   = (rawx >= limx) || (rawx <= -limx);
                    if (angle_reg > 32'(EST_MAX))
                        est_next = EST_MAX;
                    else if (angle_reg < 32'(EST_MIN))
                        est_next = EST_MIN;
                    else
                        est_next = angle_reg[26:0];
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid      = ov_reg;
        angle_estimate = est_reg;
        raw_tilt       = rout_reg;
        too_far        = far_reg;
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        k0_reg     <= k0_next;
        k1_reg     <= k1_next;
        raw_reg    <= raw_next;
        y_reg      <= y_next;
        lo_reg     <= lo_next;
        pp_reg     <= pp_next;
        q_reg      <= q_next;
        est_reg    <= est_next;
        rout_reg   <= rout_next;
        far_reg    <= far_next;
        rc_acc_reg <= rc_acc_next;
        rc_cnt_reg <= rc_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_TILT;
            angle_reg <= '0;
            bias_reg  <= '0;
            caa_reg   <= '0;
            cab_reg   <= '0;
            cba_reg   <= '0;
            cbb_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            angle_reg <= angle_next;
            bias_reg  <= bias_next;
            caa_reg   <= caa_next;
            cab_reg   <= cab_next;
            cba_reg   <= cba_next;
            cbb_reg   <= cbb_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

FILE: hw/rtl/tilt_kalman_estimator.sv
// Tilt estimator top level: configuration registers, front end, queue, sequencer.
// Depends on tke_pkg, tke_front, tke_queue, tke_back.
// Usage:
//   Input channel (in_valid/in_ready) takes one word of accel_y, accel_z,
//   gyro_x and interval_ms. Output channel (out_valid/out_ready) returns one
//   word per input: angle_estimate (signed Q10.16), raw_tilt and too_far.
//   Configuration channel (cfg_valid/cfg_ready, always ready) writes the
//   register at cfg_index with cfg_data; write only while the block is idle.
//   The sequencer handles one word at a time and takes the next from the queue
//   only after the last result is in the output register. Per word it runs the
//   64-iteration shared divider three times (arctan2 and two gains), four time
//   products by reciprocal multiplication and six gain products. Zero arctan2
//   operands skip the arctan2 divide; a zero innovation variance skips both
//   gain divides.
//   The front end queues up to QUEUE_DEPTH words while the sequencer works.
//   Reset clears the filter state and covariances to zero and loads the
//   default noise, offset and limit values.
//   When out_ready is low the result holds in the output register; the
//   sequencer stalls only once its next result is ready, and the queue then
//   fills and drops in_ready.
module tilt_kalman_estimator #(
    parameter int QUEUE_DEPTH = tke_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic signed [15:0]               accel_y,
    input  logic signed [15:0]               accel_z,
    input  logic signed [15:0]               gyro_x,
    input  logic [9:0]                       interval_ms,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [26:0]               angle_estimate,
    output logic signed [11:0]               raw_tilt,
    output logic                             too_far,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tke_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tke_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tke_pkg::*;

    tke_cfg_t  cfg_reg, cfg_next;
    logic      push, queue_full, q_valid, q_pop;
    tke_item_t push_item, q_item;

    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ANGLE_NOISE:   cfg_next.angle_noise   = cfg_data;
                CFG_BIAS_NOISE:    cfg_next.bias_noise    = cfg_data;
                CFG_MEASURE_NOISE: cfg_next.measure_noise = cfg_data;
                CFG_TILT_OFFSET:   cfg_next.tilt_offset   = $signed(cfg_data[10:0]);
                CFG_TILT_LIMIT:    cfg_next.tilt_limit    = cfg_data[9:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angle_noise   <= ANGLE_NOISE_RST;
            cfg_reg.bias_noise    <= BIAS_NOISE_RST;
            cfg_reg.measure_noise <= MEASURE_NOISE_RST;
            cfg_reg.tilt_offset   <= TILT_OFFSET_RST;
            cfg_reg.tilt_limit    <= TILT_LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tke_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .accel_y     (accel_y),
        .accel_z     (accel_z),
        .gyro_x      (gyro_x),
        .interval_ms (interval_ms),
        .queue_full  (queue_full),
        .push        (push),
        .push_item   (push_item)
    );

    tke_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_item  (q_item)
    );

    tke_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .angle_estimate (angle_estimate),
        .raw_tilt       (raw_tilt),
        .too_far        (too_far)
    );

endmodule

FILE: hw/rtl/tke_checker.sv
// Port-level checker for the tilt estimator, bound to the top level.
// Depends on tke_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tke_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [tke_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [tke_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [26:0]             angle_estimate,
    input logic signed [11:0]             raw_tilt,
    input logic                           too_far
);
    import tke_pkg::*;

    logic [9:0]         lim_reg;
    logic signed [12:0] rawx, limx;
    logic               far_exp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lim_reg <= TILT_LIMIT_RST;
        else if (cfg_valid && cfg_ready && cfg_index == CFG_TILT_LIMIT)
            lim_reg <= cfg_data[9:0];
    end

    always_comb
    begin
        rawx    = 13'(raw_tilt);
        limx    = $signed({3'd0, lim_reg});
        far_exp = (rawx >= limx) || (rawx <= -limx);
    end

    `TKE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(angle_estimate) && $stable(raw_tilt) && $stable(too_far), "output word changed while stalled")
    `TKE_ASSERT_NOW(a_far_flag, out_valid, too_far == far_exp, "too_far disagrees with raw_tilt and limit")
    `TKE_ASSERT_NOW(a_raw_range, out_valid, (rawx >= -13'sd1024) && (rawx <= 13'sd1024), "raw_tilt out of range")

endmodule

bind tilt_kalman_estimator tke_checker u_tke_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .angle_estimate (angle_estimate),
    .raw_tilt       (raw_tilt),
    .too_far        (too_far)
);

FILE: sim/tb_tilt_kalman_estimator.sv
`timescale 1ns / 100ps
// Testbench of tilt_kalman_estimator: random and directed IMU words against
// a built-in angle/bias filter predictor held in a small scoreboard class.
// Depends on tke_pkg and the tilt_kalman_estimator RTL.
module tb_tilt_kalman_estimator;
    import tke_pkg::*;

    localparam int  WATCHDOG_LIMIT = 40000;
    localparam int  SETTLE_CYCLES  = 700;
    localparam longint Q28 = 64'sd268435456;

    typedef struct {
        logic signed [26:0] angle_estimate;
        logic signed [11:0] raw_tilt;
        logic               too_far;
    } tilt_word_t;

    class tilt_scoreboard;
        tilt_word_t pending[$];
        int         errors;
        longint     ang_noise, bias_noise, meas_noise, offset, limit;
        longint     angle, bias, p_aa, p_ab, p_ba, p_bb;

        function new();
            errors     = 0;
            ang_noise  = 268435;
            bias_noise = 805306;
            meas_noise = 8053063;
            offset     = 36;
            limit      = 150;
            angle = 0; bias = 0; p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function longint arc_units(longint y, longint x);
            longint mag, val;
            mag = (y < 0) ? -y : y;
            if (x >= 0)
                val = (x == 0 && mag == 0) ? 256 : (256 * mag) / (x + mag);
            else
                val = (256 * mag - 512 * x) / (mag - x);
            return (y < 0) ? -val : val;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [28:0] data);
            case (idx)
                CFG_ANGLE_NOISE:   ang_noise  = longint'(data);
                CFG_BIAS_NOISE:    bias_noise = longint'(data);
                CFG_MEASURE_NOISE: meas_noise = longint'(data);
                CFG_TILT_OFFSET:   offset     = longint'($signed(data[10:0]));
                CFG_TILT_LIMIT:    limit      = longint'(data[9:0]);
                default: ;
            endcase
        endfunction

        function void note_input(logic signed [15:0] ay, logic signed [15:0] az,
                                 logic signed [15:0] gx, logic [9:0] ms_in);
            longint ms, rate, raw, d, innov, s, k0, k1, est;
            tilt_word_t w;
            ms   = longint'(ms_in);
            rate = (longint'(gx) * 250) / 32768;
            raw  = arc_units(-longint'(az), -longint'(ay)) - offset;
            d     = rate * 65536 - bias;
            angle = clamp32(angle + (d * ms) / 1000);
            d     = ang_noise - p_ba - p_ab;
            p_aa  = clamp32(p_aa + (d * ms) / 1000);
            d     = (p_bb * ms) / 1000;
            p_ab  = clamp32(p_ab - d);
            p_ba  = clamp32(p_ba - d);
            p_bb  = clamp32(p_bb + (bias_noise * ms) / 1000);
            innov = raw * 65536 - angle;
            s     = p_aa + meas_noise;
            if (s == 0)
            begin
                k0 = 0;
                k1 = 0;
            end
            else
            begin
                k0 = clamp32((p_aa * Q28) / s);
                k1 = clamp32((p_ba * Q28) / s);
            end
            angle = clamp32(angle + (k0 * innov) / Q28);
            bias  = clamp32(bias + (k1 * innov) / Q28);
            p_aa  = clamp32(p_aa - (k0 * p_aa) / Q28);
            p_ab  = clamp32(p_ab - (k0 * p_ab) / Q28);
            p_ba  = clamp32(p_ba - (k1 * p_aa) / Q28);
            p_bb  = clamp32(p_bb - (k1 * p_ab) / Q28);
            est = angle;
            if (est > 67108863)
                est = 67108863;
            if (est < -67108864)
                est = -67108864;
            w.angle_estimate = est[26:0];
            w.raw_tilt       = raw[11:0];
            w.too_far        = (raw >= limit || raw <= -limit);
            pending.push_back(w);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic signed [26:0] est, logic signed [11:0] raw, logic far);
            tilt_word_t w;
            if (pending.size() == 0)
            begin
                report("result word with nothing expected");
                return;
            end
            w = pending.pop_front();
            if (est !== w.angle_estimate)
                report($sformatf("angle_estimate %0d, expected %0d", est, w.angle_estimate));
            if (raw !== w.raw_tilt)
                report($sformatf("raw_tilt %0d, expected %0d", raw, w.raw_tilt));
            if (far !== w.too_far)
                report($sformatf("too_far %0b, expected %0b", far, w.too_far));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic signed [15:0]     accel_y = '0;
    logic signed [15:0]     accel_z = '0;
    logic signed [15:0]     gyro_x = '0;
    logic [9:0]             interval_ms = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic signed [26:0]     angle_estimate;
    logic signed [11:0]     raw_tilt;
    logic                   too_far;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    tilt_scoreboard tilt_sb = new();
    bit  calm = 1'b0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    int  tilt_phase = 0;

    always #6 clk = ~clk;

    tilt_kalman_estimator i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .accel_y(accel_y), .accel_z(accel_z), .gyro_x(gyro_x),
        .interval_ms(interval_ms),
        .out_valid(out_valid), .out_ready(out_ready),
        .angle_estimate(angle_estimate), .raw_tilt(raw_tilt), .too_far(too_far),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                tilt_sb.note_input(accel_y, accel_z, gyro_x, interval_ms);
            if (cfg_valid && cfg_ready)
                tilt_sb.write_register(cfg_index, cfg_data);
            if (out_valid && out_ready)
                tilt_sb.check_result(angle_estimate, raw_tilt, too_far);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task send_word(logic signed [15:0] ay, logic signed [15:0] az,
                   logic signed [15:0] gx, logic [9:0] ms);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        accel_y     <= ay;
        accel_z     <= az;
        gyro_x      <= gx;
        interval_ms <= ms;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task drain_and_settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tilt_sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [15:0] any_sample();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(int'($urandom_range(0, 20)) - 10);
            default: return 16'($urandom);
        endcase
    endfunction

    task random_words(int count);
        int   heading;
        logic signed [15:0] ay, az, gx;
        logic [9:0] ms;
        heading = $urandom_range(0, 1023);
        for (int n = 0; n < count; n++)
        begin
            if (n > count - 120 && tilt_phase == 5)
                calm = 1'b1;
            if ($urandom_range(0, 9) < 7)
            begin
                heading = (heading + int'($urandom_range(0, 40)) - 20) & 1023;
                ay = 16'(int'(16000.0 * $cos(heading * 6.2831853 / 1024.0))
                         + int'($urandom_range(0, 400)) - 200);
                az = 16'(int'(16000.0 * $sin(heading * 6.2831853 / 1024.0))
                         + int'($urandom_range(0, 400)) - 200);
                gx = 16'(int'($urandom_range(0, 4000)) - 2000);
                ms = 10'($urandom_range(1, 25));
            end
            else
            begin
                ay = any_sample();
                az = any_sample();
                gx = any_sample();
                ms = ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1)) * 10'd1000
                                                 : 10'($urandom_range(0, 1000));
                if (ms == 10'd0 && $urandom_range(0, 1) == 0)
                    ms = 10'($urandom_range(512, 1000));
            end
            send_word(ay, az, gx, ms);
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_word(16'sd0, 16'sd0, 16'sd0, 10'd0);
        send_word(16'sh7FFF, 16'sd0, 16'sh7FFF, 10'd1000);
        send_word(16'sh8000, 16'sd0, 16'sh8000, 10'd1000);
        send_word(16'sd0, 16'sh7FFF, 16'sd131, 10'd1);
        send_word(16'sd0, 16'sh8000, -16'sd131, 10'd10);
        send_word(16'sh8000, 16'sh8000, 16'sd0, 10'd512);
        send_word(16'sh7FFF, 16'sh7FFF, 16'sd0, 10'd0);
        send_word(16'sh7FFF, 16'sh8000, 16'sd1, 10'd7);
        send_word(16'sh8000, 16'sh7FFF, -16'sd1, 10'd999);
        send_word(-16'sd1, 16'sd0, 16'sd0, 10'd20);
        drain_and_settle();

        tilt_phase = 1;
        write_cfg(CFG_ANGLE_NOISE, 29'd0);
        write_cfg(CFG_BIAS_NOISE, 29'd0);
        write_cfg(CFG_MEASURE_NOISE, 29'd268435456);
        write_cfg(CFG_TILT_OFFSET, 29'(11'sh200));
        write_cfg(CFG_TILT_LIMIT, 29'd0);
        for (int n = 0; n < 12; n++)
            send_word(16'sh8000, 16'sd0, 16'sh7FFF, 10'd1000);
        drain_and_settle();

        tilt_phase = 2;
        write_cfg(CFG_ANGLE_NOISE, 29'd268435456);
        write_cfg(CFG_BIAS_NOISE, 29'd268435456);
        write_cfg(CFG_MEASURE_NOISE, 29'd1);
        write_cfg(CFG_TILT_OFFSET, 29'(-11'sd512));
        write_cfg(CFG_TILT_LIMIT, 29'd600);
        random_words(300);
        drain_and_settle();

        for (tilt_phase = 3; tilt_phase <= 5; tilt_phase++)
        begin
            write_cfg(CFG_ANGLE_NOISE, 29'($urandom_range(0, 268435456)));
            write_cfg(CFG_BIAS_NOISE, 29'($urandom_range(0, 268435456)));
            write_cfg(CFG_MEASURE_NOISE, 29'($urandom_range(1, 268435456)));
            write_cfg(CFG_TILT_OFFSET, 29'(11'(int'($urandom_range(0, 1024)) - 512)));
            write_cfg(CFG_TILT_LIMIT, 29'($urandom_range(0, 600)));
            random_words(tilt_phase == 5 ? 480 : 420);
            drain_and_settle();
        end

        if (tilt_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
